[sv/split_flap_stepper_positioner_defines.svh]
// Assertion macros for the split-flap stepper positioner checker.
// Expects clk and arst_n in the scope of use.
`ifndef SPLIT_FLAP_STEPPER_POSITIONER_DEFINES_SVH
`define SPLIT_FLAP_STEPPER_POSITIONER_DEFINES_SVH

// same-cycle implication
`define SFSP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfsp assertion failed");

// next-cycle implication
`define SFSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfsp assertion failed");

`endif

[sv/sfsp_pkg.sv]
// Shared types, codes, constants and the ramp delay function.
// No dependencies.
`default_nettype none

package sfsp_pkg;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_MSG    = 2'd1,
		REQ_SENSOR = 2'd2,
		REQ_HOME   = 2'd3
	} req_kind_t;

	localparam logic [1:0] CFG_STEPS_PER_DIGIT = 2'd0;
	localparam logic [1:0] CFG_DIGIT_COUNT     = 2'd1;
	localparam logic [1:0] CFG_ZERO_OFFSET     = 2'd2;
	localparam logic [1:0] CFG_BUS_ADDRESS     = 2'd3;

	localparam logic [7:0] OPC_SET_DIGIT = 8'hBA;
	localparam logic [5:0] MSG_LEN_SET   = 6'd3;

	localparam logic [15:0] RAMP_FAST_MIN = 16'd20;
	localparam logic [15:0] RAMP_MID_MIN  = 16'd10;
	localparam logic [15:0] RAMP_SLOW_MIN = 16'd5;

	localparam logic [3:0] DELAY_FAST  = 4'd3;
	localparam logic [3:0] DELAY_MID   = 4'd6;
	localparam logic [3:0] DELAY_SLOW  = 4'd9;
	localparam logic [3:0] DELAY_CRAWL = 4'd10;

	typedef struct packed {
		logic [7:0] steps_per_digit;
		logic [7:0] digit_count;
		logic [7:0] zero_offset;
		logic [7:0] bus_address;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		req_kind_t   kind;
		logic        blocked;
		logic        msg_ok;
		logic [15:0] tgt;
		logic [15:0] total;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic        pulse;
		logic        coil;
		logic [15:0] pos;
		logic [15:0] tgt;
	} result_t;

	function automatic logic [3:0] ramp_delay(input logic [15:0] taken,
		input logic [15:0] left);
		logic [3:0] d;
		if (taken > RAMP_FAST_MIN && left > RAMP_FAST_MIN) begin
			d = DELAY_FAST;
		end else if (taken > RAMP_MID_MIN && left > RAMP_MID_MIN) begin
			d = DELAY_MID;
		end else if (taken > RAMP_SLOW_MIN && left > RAMP_SLOW_MIN) begin
			d = DELAY_SLOW;
		end else begin
			d = DELAY_CRAWL;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

[sv/sfsp_front.sv]
// Input register, product stage and target reduction stage.
// Depends on sfsp_pkg.
`default_nettype none

module sfsp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire logic          in_valid,
	input  wire logic [1:0]    req_type,
	input  wire logic [5:0]    msg_len,
	input  wire logic [7:0]    cmd_opcode,
	input  wire logic [7:0]    cmd_address,
	input  wire logic [7:0]    cmd_digit,
	input  wire logic          sensor_blocked,
	input  wire sfsp_pkg::cfg_t cfg,
	output sfsp_pkg::item_t    item
);

	logic       valid_s1;
	logic [1:0] req_type_s1;
	logic [5:0] msg_len_s1;
	logic [7:0] opcode_s1;
	logic [7:0] address_s1;
	logic [7:0] digit_s1;
	logic       blocked_s1;

	sfsp_pkg::item_t item_s2;
	sfsp_pkg::item_t item_s3;
	sfsp_pkg::item_t item_s2_d;
	sfsp_pkg::item_t item_s3_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			req_type_s1 <= req_type;
			msg_len_s1  <= msg_len;
			opcode_s1   <= cmd_opcode;
			address_s1  <= cmd_address;
			digit_s1    <= cmd_digit;
			blocked_s1  <= sensor_blocked;
		end
	end

	// products
	always_comb begin
		item_s2_d.valid   = valid_s1;
		item_s2_d.kind    = sfsp_pkg::req_kind_t'(req_type_s1);
		item_s2_d.blocked = blocked_s1;
		item_s2_d.msg_ok  = (msg_len_s1 == sfsp_pkg::MSG_LEN_SET) &&
			(opcode_s1 == sfsp_pkg::OPC_SET_DIGIT) && (address_s1 == cfg.bus_address);
		item_s2_d.tgt     = (16'(digit_s1) * 16'(cfg.steps_per_digit)) +
			16'(cfg.zero_offset);
		item_s2_d.total   = 16'(cfg.steps_per_digit) * 16'(cfg.digit_count);
	end

	// single wrap of the target
	always_comb begin
		item_s3_d = item_s2;
		if (item_s2.tgt > item_s2.total) begin
			item_s3_d.tgt = item_s2.tgt - item_s2.total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
			item_s3 <= '0;
		end else if (advance) begin
			item_s2 <= item_s2_d;
			item_s3 <= item_s3_d;
		end
	end

	assign item = item_s3;

endmodule

`default_nettype wire

[sv/sfsp_core.sv]
// Positioner state, event handling and result register.
// Depends on sfsp_pkg.
`default_nettype none

module sfsp_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire sfsp_pkg::item_t item,
	input  wire logic [7:0]    steps_per_digit,
	input  wire logic [7:0]    zero_offset,
	output sfsp_pkg::result_t  result
);

	logic [15:0] position_q;
	logic [15:0] target_q;
	logic [15:0] remaining_q;
	logic [15:0] taken_q;
	logic [3:0]  wait_q;
	logic        motion_q;

	logic [15:0] position_d;
	logic [15:0] target_d;
	logic [15:0] remaining_d;
	logic [15:0] taken_d;
	logic [3:0]  wait_d;
	logic        motion_d;
	logic        pulse_d;

	logic [15:0] rem_sum;
	logic [15:0] taken_base;
	logic [3:0]  delay;

	sfsp_pkg::result_t result_q;

	always_comb begin
		rem_sum    = item.total + item.tgt - position_q;
		taken_base = motion_q ? taken_q : 16'd0;
		delay      = sfsp_pkg::ramp_delay(taken_base, remaining_q);

		position_d  = position_q;
		target_d    = target_q;
		remaining_d = remaining_q;
		taken_d     = taken_q;
		wait_d      = wait_q;
		motion_d    = motion_q;
		pulse_d     = 1'b0;

		unique case (item.kind)
			sfsp_pkg::REQ_TICK: begin
				if (wait_q != 4'd0) begin
					wait_d = wait_q - 4'd1;
				end else if (position_q != target_q) begin
					pulse_d     = 1'b1;
					motion_d    = 1'b1;
					position_d  = position_q + 16'd1;
					wait_d      = delay - 4'd1;
					taken_d     = taken_base + 16'd1;
					remaining_d = remaining_q - 16'd1;
				end else begin
					motion_d = 1'b0;
				end
			end
			sfsp_pkg::REQ_MSG: begin
				if (item.msg_ok) begin
					target_d    = item.tgt;
					remaining_d = (rem_sum >= item.total) ? rem_sum - item.total : rem_sum;
				end
			end
			sfsp_pkg::REQ_SENSOR: begin
				if (!item.blocked && position_q > 16'(steps_per_digit)) begin
					position_d = 16'd0;
				end
			end
			sfsp_pkg::REQ_HOME: begin
				position_d  = 16'(zero_offset);
				target_d    = 16'(zero_offset);
				remaining_d = 16'd0;
				taken_d     = 16'd0;
				wait_d      = 4'd0;
				motion_d    = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= 16'd0;
			target_q    <= 16'd0;
			remaining_q <= 16'd0;
			taken_q     <= 16'd0;
			wait_q      <= 4'd0;
			motion_q    <= 1'b0;
		end else if (advance && item.valid) begin
			position_q  <= position_d;
			target_q    <= target_d;
			remaining_q <= remaining_d;
			taken_q     <= taken_d;
			wait_q      <= wait_d;
			motion_q    <= motion_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= '0;
		end else if (advance) begin
			result_q.valid <= item.valid;
			result_q.pulse <= pulse_d;
			result_q.coil  <= motion_d;
			result_q.pos   <= position_d;
			result_q.tgt   <= target_d;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

[sv/split_flap_stepper_positioner.sv]
// A transaction passes the input, product, reduction and result registers in turn.
// Throughput: one transaction per cycle; the four-stage pipeline advances whenever
// the output register is empty or being taken, and holds as a whole otherwise.
// Reset: arst_n clears position, target, step counters, ramp wait, motion flag,
// all pipeline valid bits and the four configuration registers to zero.
`default_nettype none

module split_flap_stepper_positioner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [5:0]  msg_len,
	input  wire logic [7:0]  cmd_opcode,
	input  wire logic [7:0]  cmd_address,
	input  wire logic [7:0]  cmd_digit,
	input  wire logic        sensor_blocked,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             step_pulse,
	output logic             coil_current_high,
	output logic [15:0]      position_now,
	output logic [15:0]      target_now
);

	sfsp_pkg::cfg_t    cfg_q;
	sfsp_pkg::item_t   item;
	sfsp_pkg::result_t result;
	logic              advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sfsp_pkg::CFG_STEPS_PER_DIGIT: cfg_q.steps_per_digit <= cfg_wdata;
				sfsp_pkg::CFG_DIGIT_COUNT:     cfg_q.digit_count     <= cfg_wdata;
				sfsp_pkg::CFG_ZERO_OFFSET:     cfg_q.zero_offset     <= cfg_wdata;
				sfsp_pkg::CFG_BUS_ADDRESS:     cfg_q.bus_address     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign advance  = !result.valid || !out_stall;
	assign in_stall = !advance;

	sfsp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.in_valid       (in_valid),
		.req_type       (req_type),
		.msg_len        (msg_len),
		.cmd_opcode     (cmd_opcode),
		.cmd_address    (cmd_address),
		.cmd_digit      (cmd_digit),
		.sensor_blocked (sensor_blocked),
		.cfg            (cfg_q),
		.item           (item)
	);

	sfsp_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.item            (item),
		.steps_per_digit (cfg_q.steps_per_digit),
		.zero_offset     (cfg_q.zero_offset),
		.result          (result)
	);

	assign out_valid         = result.valid;
	assign step_pulse        = result.pulse;
	assign coil_current_high = result.coil;
	assign position_now      = result.pos;
	assign target_now        = result.tgt;

endmodule

`default_nettype wire

[sv/sfsp_checker.sv]
// Port-level checker for the split-flap stepper positioner, with its bind.
// Depends on split_flap_stepper_positioner_defines.svh.
`default_nettype none
`include "split_flap_stepper_positioner_defines.svh"

module sfsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_we,
	input wire logic [1:0]  cfg_idx,
	input wire logic [7:0]  cfg_wdata,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [1:0]  req_type,
	input wire logic [5:0]  msg_len,
	input wire logic [7:0]  cmd_opcode,
	input wire logic [7:0]  cmd_address,
	input wire logic [7:0]  cmd_digit,
	input wire logic        sensor_blocked,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        step_pulse,
	input wire logic        coil_current_high,
	input wire logic [15:0] position_now,
	input wire logic [15:0] target_now
);

	logic out_take;
	logic prev_pulse_q;

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pulse_q <= 1'b0;
		end else if (out_take) begin
			prev_pulse_q <= step_pulse;
		end
	end

	// a step always comes with drive current on
	`SFSP_ASSERT_IMP(a_step_has_current, out_valid && step_pulse, coil_current_high)

	// ramp delay is never below three ticks, so steps never come in adjacent results
	`SFSP_ASSERT_IMP(a_no_adjacent_steps, out_take && step_pulse, !prev_pulse_q)

	// input side only stalls on a blocked result
	`SFSP_ASSERT_IMP(a_stall_only_on_backpressure, !out_valid || !out_stall, !in_stall)

	`SFSP_ASSERT_NEXT(a_result_holds, out_valid && out_stall,
		out_valid && $stable(position_now) && $stable(target_now))

endmodule

bind split_flap_stepper_positioner sfsp_checker u_sfsp_checker (.*);

`default_nettype wire
